// File: sv/csvt_pkg.sv
package csvt_pkg;

  localparam int HOLD_DEPTH = 16;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W      = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] KIND_BYTE      = 3'd0;
  localparam logic [2:0] KIND_FIELD_END = 3'd1;
  localparam logic [2:0] KIND_LINE_END  = 3'd2;
  localparam logic [2:0] KIND_UNTERM    = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic take;
    logic load_held;
    logic load_final;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic flush_req;
    logic flush_last;
  } stat_t;

endpackage

// File: sv/csvt_ctrl.sv
module csvt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           out_tready,
  input  csvt_pkg::stat_t stat,
  output csvt_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_free;

  assign out_free = !stat.out_busy || out_tready;

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    cmd.take       = 1'b0;
    cmd.load_held  = 1'b0;
    cmd.load_final = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = out_free;
        if (in_tvalid && out_free) begin
          cmd.take = 1'b1;
          if (stat.flush_req) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (stat.flush_last) begin
            cmd.load_final = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.load_held = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/csvt_dp.sv
module csvt_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_byte,
  input  logic            end_of_line,
  input  logic            out_tready,
  input  csvt_pkg::cmd_t  cmd,
  output csvt_pkg::stat_t stat,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            out_last
);

  logic                       in_quotes_r, in_quotes_nxt;
  logic                       quote_pend_r, quote_pend_nxt;
  logic                       started_r, started_nxt;
  logic [csvt_pkg::CNT_W-1:0] held_cnt_r, held_cnt_nxt;
  logic [csvt_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]                 held_r [csvt_pkg::HOLD_DEPTH];
  logic [7:0]                 pend_byte_r, pend_byte_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, out_byte_nxt;
  logic [2:0]                 out_kind_r, out_kind_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       dec_iq, dec_qp, dec_started, dec_emit, dec_flush, dec_hold;
  logic [csvt_pkg::CNT_W-1:0] dec_cnt;
  logic [2:0]                 dec_kind;
  logic [7:0]                 dec_byte;
  logic                       iq_eff, content, is_quote, is_comma, is_space;
  logic                       hold_wr;

  assign is_quote = in_byte == csvt_pkg::CH_QUOTE;
  assign is_comma = in_byte == csvt_pkg::CH_COMMA;
  assign is_space = in_byte == csvt_pkg::CH_SPACE || in_byte == csvt_pkg::CH_TAB ||
                    in_byte == csvt_pkg::CH_CR || in_byte == csvt_pkg::CH_LF;
  assign iq_eff   = quote_pend_r ? 1'b0 : in_quotes_r;

  always_comb begin
    dec_iq      = in_quotes_r;
    dec_qp      = 1'b0;
    dec_started = started_r;
    dec_cnt     = held_cnt_r;
    dec_emit    = 1'b0;
    dec_flush   = 1'b0;
    dec_hold    = 1'b0;
    dec_kind    = csvt_pkg::KIND_BYTE;
    dec_byte    = 8'd0;
    content     = 1'b0;
    if (quote_pend_r && !end_of_line && is_quote) begin
      content = 1'b1;
    end else begin
      dec_iq = iq_eff;
      if (end_of_line) begin
        dec_emit    = 1'b1;
        dec_kind    = iq_eff ? csvt_pkg::KIND_UNTERM : csvt_pkg::KIND_LINE_END;
        dec_iq      = 1'b0;
        dec_started = 1'b0;
        dec_cnt     = '0;
      end else if (is_quote) begin
        if (iq_eff) begin
          dec_qp = 1'b1;
        end else begin
          dec_iq = 1'b1;
        end
      end else if (is_comma && !iq_eff) begin
        dec_emit    = 1'b1;
        dec_kind    = csvt_pkg::KIND_FIELD_END;
        dec_started = 1'b0;
        dec_cnt     = '0;
      end else begin
        content = 1'b1;
      end
    end
    if (content) begin
      if (is_space) begin
        if (started_r) begin
          if (held_cnt_r < csvt_pkg::CNT_W'(csvt_pkg::HOLD_DEPTH)) begin
            dec_hold = 1'b1;
            dec_cnt  = held_cnt_r + csvt_pkg::CNT_W'(1);
          end else begin
            dec_emit = 1'b1;
            dec_kind = csvt_pkg::KIND_OVERFLOW;
          end
        end
      end else begin
        dec_started = 1'b1;
        if (held_cnt_r != '0) begin
          dec_flush = 1'b1;
        end else begin
          dec_emit = 1'b1;
          dec_byte = in_byte;
        end
      end
    end
  end

  always_comb begin
    in_quotes_nxt  = in_quotes_r;
    quote_pend_nxt = quote_pend_r;
    started_nxt    = started_r;
    held_cnt_nxt   = held_cnt_r;
    idx_nxt        = idx_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    hold_wr        = 1'b0;
    if (cmd.take) begin
      in_quotes_nxt  = dec_iq;
      quote_pend_nxt = dec_qp;
      started_nxt    = dec_started;
      held_cnt_nxt   = dec_cnt;
      hold_wr        = dec_hold;
      if (dec_flush) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = held_r[0];
        out_kind_nxt  = csvt_pkg::KIND_BYTE;
        out_last_nxt  = 1'b0;
        idx_nxt       = csvt_pkg::CNT_W'(1);
        pend_byte_nxt = in_byte;
      end else if (dec_emit) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = dec_byte;
        out_kind_nxt  = dec_kind;
        out_last_nxt  = 1'b1;
      end
    end else if (cmd.load_held) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = held_r[idx_r[csvt_pkg::IDX_W-1:0]];
      out_kind_nxt  = csvt_pkg::KIND_BYTE;
      out_last_nxt  = 1'b0;
      idx_nxt       = idx_r + csvt_pkg::CNT_W'(1);
    end else if (cmd.load_final) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pend_byte_r;
      out_kind_nxt  = csvt_pkg::KIND_BYTE;
      out_last_nxt  = 1'b1;
      held_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r  <= 1'b0;
      quote_pend_r <= 1'b0;
      started_r    <= 1'b0;
      held_cnt_r   <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_quotes_r  <= in_quotes_nxt;
      quote_pend_r <= quote_pend_nxt;
      started_r    <= started_nxt;
      held_cnt_r   <= held_cnt_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
    if (hold_wr) begin
      held_r[held_cnt_r[csvt_pkg::IDX_W-1:0]] <= in_byte;
    end
  end

  assign stat.out_busy   = out_valid_r;
  assign stat.flush_req  = dec_flush;
  assign stat.flush_last = idx_r == held_cnt_r;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule

// File: sv/csv_field_tokenizer_top.sv
// CSV field tokenizer for one line at a time.
// The input stream carries one character per request in in_tdata, or an
// end-of-line marker when in_tuser is high. The output stream carries one
// result per transfer: a content byte, a field end, a field and line end,
// an unterminated quote or a whitespace overflow, with out_tlast marking
// the final result caused by one input request.
// An input request that causes at most one result, or none, does not hold
// off input, and its result appears on the output in the cycle after acceptance.
// A content byte that follows held inner whitespace causes one result per
// held byte, up to 16, and then its own, while the hold buffer is drained through
// the output register; input is not accepted during that burst.
// The output register lets a new input request be accepted in the same cycle
// in which the waiting result is taken. When the receiver stalls, the result
// stays in the output register and input is held off.
// Reset clears quote mode, the field state and the hold count, and empties
// the output register.
module csv_field_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] end_of_line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [2:0] kind
  output logic       out_tlast
);

  csvt_pkg::cmd_t  cmd;
  csvt_pkg::stat_t stat;

  csvt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  csvt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_tdata),
    .end_of_line (in_tuser[0]),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_tvalid),
    .out_byte    (out_tdata),
    .out_kind    (out_tuser),
    .out_last    (out_tlast)
  );

endmodule

// File: sv/csvt_chk.sv
module csvt_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= csvt_pkg::KIND_OVERFLOW)
    else $error("Result kind out of range.");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != csvt_pkg::KIND_BYTE) |-> out_tdata == 8'd0)
    else $error("Marker result carries a nonzero byte.");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != csvt_pkg::KIND_BYTE) |-> out_tlast)
    else $error("Marker result is not the last of its run.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast)))
    else $error("Stalled result changed.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind csv_field_tokenizer_top csvt_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// File: test/csv_field_tokenizer_top_test.sv
`timescale 1ns / 1ps

module csv_field_tokenizer_top_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int TAIL_CYCLES = 24;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic       last;
  } token_t;

  class field_token_board;
    logic in_quotes;
    logic quote_wait;
    logic field_live;
    logic [7:0] held_ws[csvt_pkg::HOLD_DEPTH];
    int held_cnt;
    token_t step_tokens[$];
    token_t expected_tokens[$];
    int kind_count[8];
    int errors;
    int checked;

    function new();
      in_quotes = 1'b0;
      quote_wait = 1'b0;
      field_live = 1'b0;
      held_cnt = 0;
      errors = 0;
      checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == csvt_pkg::CH_SPACE || c == csvt_pkg::CH_TAB ||
             c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF;
    endfunction

    function void emit(logic [7:0] d, logic [2:0] k);
      token_t t;
      t.data = d;
      t.kind = k;
      t.last = 1'b0;
      step_tokens = {step_tokens, t};
    endfunction

    function void close_field();
      field_live = 1'b0;
      held_cnt = 0;
    endfunction

    function void take_content(logic [7:0] c);
      if (is_ws(c)) begin
        if (!field_live) return;
        if (held_cnt < csvt_pkg::HOLD_DEPTH) begin
          held_ws[held_cnt] = c;
          held_cnt++;
        end else begin
          emit(8'h00, csvt_pkg::KIND_OVERFLOW);
        end
        return;
      end
      for (int i = 0; i < held_cnt; i++) emit(held_ws[i], csvt_pkg::KIND_BYTE);
      held_cnt = 0;
      field_live = 1'b1;
      emit(c, csvt_pkg::KIND_BYTE);
    endfunction

    function void note_request(logic [7:0] c, logic eol);
      step_tokens.delete();
      if (quote_wait && !eol && c == csvt_pkg::CH_QUOTE) begin
        quote_wait = 1'b0;
        take_content(csvt_pkg::CH_QUOTE);
      end else begin
        if (quote_wait) begin
          quote_wait = 1'b0;
          in_quotes = 1'b0;
        end
        if (eol) begin
          emit(8'h00, in_quotes ? csvt_pkg::KIND_UNTERM : csvt_pkg::KIND_LINE_END);
          in_quotes = 1'b0;
          close_field();
        end else if (c == csvt_pkg::CH_QUOTE) begin
          if (in_quotes) quote_wait = 1'b1;
          else in_quotes = 1'b1;
        end else if (c == csvt_pkg::CH_COMMA && !in_quotes) begin
          emit(8'h00, csvt_pkg::KIND_FIELD_END);
          close_field();
        end else begin
          take_content(c);
        end
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) begin
        kind_count[step_tokens[i].kind]++;
        expected_tokens = {expected_tokens, step_tokens[i]};
      end
    endfunction

    function void check_result(logic [7:0] d, logic [2:0] k, logic l);
      token_t want;
      if (expected_tokens.size() == 0) begin
        $error("unexpected result: out_byte %02h kind %0d last_of_run %0b", d, k, l);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (d !== want.data) begin
        $error("out_byte mismatch: expected %02h, got %02h", want.data, d);
        errors++;
      end
      if (k !== want.kind) begin
        $error("kind mismatch: expected %0d, got %0d", want.kind, k);
        errors++;
      end
      if (l !== want.last) begin
        $error("last_of_run mismatch: expected %0b, got %0b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic [0:0] in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [2:0] out_tuser;
  logic       out_tlast;

  field_token_board board;
  int cycles;
  int in_idle_pct;
  int out_stall_pct;
  int requests_taken;
  int lines_sent;

  csv_field_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("FAIL csv_field_tokenizer_top");
    $finish;
  end

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 3))
      0: return csvt_pkg::CH_SPACE;
      1: return csvt_pkg::CH_TAB;
      2: return csvt_pkg::CH_CR;
      default: return csvt_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == csvt_pkg::CH_QUOTE || c == csvt_pkg::CH_COMMA ||
               c == csvt_pkg::CH_SPACE || c == csvt_pkg::CH_TAB ||
               c == csvt_pkg::CH_CR || c == csvt_pkg::CH_LF);
    return c;
  endfunction

  task automatic send_req(input logic [7:0] c, input logic eol);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tuser <= eol;
    do @(posedge clk); while (!in_tready);
    board.note_request(c, eol);
    requests_taken++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic send_line();
    int nf;
    int len;
    bit quoted;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_req(csvt_pkg::CH_COMMA, 1'b0);
      repeat ($urandom_range(0, 2)) send_req(pick_space(), 1'b0);
      quoted = 1'($urandom_range(0, 1));
      if (quoted) send_req(csvt_pkg::CH_QUOTE, 1'b0);
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 3)) send_req(pick_space(), 1'b0);
          1: begin
            if (quoted) begin
              send_req(csvt_pkg::CH_QUOTE, 1'b0);
              send_req(csvt_pkg::CH_QUOTE, 1'b0);
            end else begin
              send_req(pick_plain(), 1'b0);
            end
          end
          2: send_req(quoted ? csvt_pkg::CH_COMMA : pick_plain(), 1'b0);
          3: begin
            send_req(pick_plain(), 1'b0);
            if ($urandom_range(0, 3) == 0) begin
              repeat ($urandom_range(csvt_pkg::HOLD_DEPTH - 1, csvt_pkg::HOLD_DEPTH + 3)) begin
                send_req(pick_space(), 1'b0);
              end
              send_req(pick_plain(), 1'b0);
            end
          end
          default: send_req(pick_plain(), 1'b0);
        endcase
      end
      if (quoted && (f < nf - 1 || $urandom_range(0, 5) != 0)) begin
        send_req(csvt_pkg::CH_QUOTE, 1'b0);
      end
      repeat ($urandom_range(0, 2)) send_req(pick_space(), 1'b0);
    end
    send_req(8'($urandom_range(0, 255)), 1'b1);
    lines_sent++;
  endtask

  initial begin
    board = new();
    in_idle_pct = 0;
    out_stall_pct = 0;
    requests_taken = 0;
    lines_sent = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_req(8'hFF, 1'b1);
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    send_req(csvt_pkg::CH_SPACE, 1'b0);
    send_req(csvt_pkg::CH_TAB, 1'b0);
    send_req("a", 1'b0);
    send_req(csvt_pkg::CH_CR, 1'b0);
    send_req(csvt_pkg::CH_COMMA, 1'b0);
    send_req(csvt_pkg::CH_LF, 1'b0);
    send_req(csvt_pkg::CH_QUOTE, 1'b0);
    send_req(csvt_pkg::CH_COMMA, 1'b0);
    send_req(csvt_pkg::CH_QUOTE, 1'b0);
    send_req(csvt_pkg::CH_QUOTE, 1'b0);
    send_req(csvt_pkg::CH_QUOTE, 1'b0);
    send_req(8'h00, 1'b1);
    send_req(csvt_pkg::CH_QUOTE, 1'b0);
    send_req("b", 1'b0);
    send_req(8'h55, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      int start;
      case (ph)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 69; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 69; end
        default: begin in_idle_pct = 19; out_stall_pct = 19; end
      endcase
      start = requests_taken;
      while (requests_taken - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            send_req(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
          end
        end else begin
          send_line();
        end
      end
      drain();
    end

    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
    end
    $display("Sent %0d requests, mixing random bytes with %0d generated lines.",
             requests_taken, lines_sent);
    $display("Checked %0d results: %0d field, %0d line, %0d quote, %0d overflow markers.",
             board.checked, board.kind_count[csvt_pkg::KIND_FIELD_END],
             board.kind_count[csvt_pkg::KIND_LINE_END],
             board.kind_count[csvt_pkg::KIND_UNTERM],
             board.kind_count[csvt_pkg::KIND_OVERFLOW]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS csv_field_tokenizer_top");
    end else begin
      $display("FAIL csv_field_tokenizer_top");
    end
    $finish;
  end

endmodule
